FILE: hdl/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared sizes, command and result types for the k-way sorted merge.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int LANES      = 4;
	localparam int LANE_DEPTH = 16;

	localparam int VALUE_W = 32;
	localparam int CFG_W   = 3;
	localparam int LANE_W  = $clog2(LANES);
	localparam int FILL_W  = $clog2(LANE_DEPTH + 1);
	localparam int ADDR_W  = $clog2(LANES * LANE_DEPTH);

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_DROP  = 2'd1,
		CMD_MERGE = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                  kind;
		logic [LANE_W-1:0]          lane;
		logic signed [VALUE_W-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  value;
		logic [LANE_W-1:0]          lane;
		logic                       empty_res;
		logic                       last;
		logic                       overflow;
	} res_t;

endpackage

FILE: hdl/k_way_sorted_merge.sv
// ----------------------------------------------------------------------------
// k_way_sorted_merge
// Appends values to lane lists and merges the active lanes in sorted order.
// ----------------------------------------------------------------------------
// Input side is a queue: an item transfers when push is high and full is low.
// mode 0 appends value to lane; mode 1 merges all active lanes and emits them.
// Result side is a queue: the oldest result sits on the ports while empty is
// low and transfers when pop is high. A merge emits its values smallest first
// (lowest lane on ties), last set on the final one, or a single result with
// empty_res set when no lane holds data. overflow reports a dropped push
// (full lane or lane at or above lanes_in_use) since the previous merge.
// A two-entry command queue feeds the executing back end. A merge picks
// each result and then waits on the lane store read that refills the
// winning lane's head before the next pick. While a merge runs no command is
// taken, so full rises once the command queue holds two items.
// A full result queue holds the merge in place until pop frees an entry.
// Reset empties all lanes and queues, clears overflow and sets
// lanes_in_use to 4. Write cfg_wdata with cfg_we only while the block is idle.
// ----------------------------------------------------------------------------
module k_way_sorted_merge import kwm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       push,
	output logic                       full,
	input  logic                       mode,
	input  logic [LANE_W-1:0]          lane,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [VALUE_W-1:0]  out_value,
	output logic [LANE_W-1:0]          out_lane,
	output logic                       empty_res,
	output logic                       last,
	output logic                       overflow
);

	logic [CFG_W-1:0] lanes_q;
	logic             cmd_valid;
	logic             cmd_ready;
	cmd_t             cmd;
	res_t             res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q <= CFG_RESET;
		end else if (cfg_we) begin
			lanes_q <= cfg_wdata;
		end
	end

	kwm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.lane         (lane),
		.value        (value),
		.lanes_in_use (lanes_q),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd)
	);

	kwm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.lanes_in_use (lanes_q),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.res_empty    (empty),
		.res_pop      (pop),
		.res          (res)
	);

	assign out_value = res.value;
	assign out_lane  = res.lane;
	assign empty_res = res.empty_res;
	assign last      = res.last;
	assign overflow  = res.overflow;

endmodule

FILE: hdl/kwm_front.sv
// ----------------------------------------------------------------------------
// kwm_front
// Accepts input items, classifies them as push, drop or merge, and holds
// them in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module kwm_front import kwm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       mode,
	input  logic [LANE_W-1:0]          lane,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic [CFG_W-1:0]           lanes_in_use,
	output logic                       cmd_valid,
	input  logic                       cmd_ready,
	output cmd_t                       cmd
);

	cmd_t       cmd_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	cmd_t       new_cmd;
	logic       lane_ok;
	logic       do_wr;
	logic       do_rd;

	// A push only lands on a lane below both the active count and the lane total.
	always_comb begin
		lane_ok = (32'(lane) < 32'(lanes_in_use)) && (32'(lane) < 32'(LANES));
		new_cmd.lane  = lane;
		new_cmd.value = value;
		if (mode) begin
			new_cmd.kind = CMD_MERGE;
		end else if (lane_ok) begin
			new_cmd.kind = CMD_PUSH;
		end else begin
			new_cmd.kind = CMD_DROP;
		end
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = cmd_q[rd_q];
	assign do_wr     = push && !full;
	assign do_rd     = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_q <= !wr_q;
			end
			if (do_rd) begin
				rd_q <= !rd_q;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			cmd_q[wr_q] <= new_cmd;
		end
	end

endmodule

FILE: hdl/kwm_back.sv
// ----------------------------------------------------------------------------
// kwm_back
// Executes commands: appends pushes to the lane store, runs the merge by
// repeated minimum selection over lane heads, and queues results.
// ----------------------------------------------------------------------------
module kwm_back import kwm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CFG_W-1:0]  lanes_in_use,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cmd_t              cmd,
	output logic              res_empty,
	input  logic              res_pop,
	output res_t              res
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_PICK = 3'b010,
		ST_LOAD = 3'b100
	} state_t;

	state_t                      state_q;
	logic [FILL_W-1:0]           fill_q [LANES];
	logic [FILL_W-1:0]           ptr_q  [LANES];
	logic signed [VALUE_W-1:0]   head_q [LANES];
	logic signed [VALUE_W-1:0]   mem    [LANES * LANE_DEPTH];
	logic signed [VALUE_W-1:0]   rd_data_q;
	logic                        drop_q;
	logic                        ovf_q;
	logic [LANE_W-1:0]           win_q;

	res_t                        res_q [2];
	logic                        res_wr_q;
	logic                        res_rd_q;
	logic [1:0]                  res_cnt_q;
	logic                        res_full;
	logic                        res_push;
	res_t                        res_new;

	logic [LANES-1:0]            live;
	logic                        found;
	logic [LANE_W-1:0]           best;
	logic signed [VALUE_W-1:0]   best_val;
	logic                        others;
	logic                        last_c;
	logic [FILL_W-1:0]           ptr_next;
	logic [ADDR_W-1:0]           rd_addr;
	logic [ADDR_W-1:0]           wr_addr;
	logic                        take_cmd;
	logic                        push_ok;

	// Minimum over the live lane heads; strict less keeps the lowest lane on ties.
	always_comb begin
		found    = 1'b0;
		best     = '0;
		best_val = '0;
		for (int i = 0; i < LANES; i++) begin
			live[i] = (i < int'(lanes_in_use)) && (ptr_q[i] < fill_q[i]);
			if (live[i] && (!found || (head_q[i] < best_val))) begin
				found    = 1'b1;
				best     = LANE_W'(i);
				best_val = head_q[i];
			end
		end
		others = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			if (live[i] && (LANE_W'(i) != best)) begin
				others = 1'b1;
			end
		end
		ptr_next = ptr_q[best] + FILL_W'(1);
		last_c   = !others && (ptr_next == fill_q[best]);
		rd_addr  = ADDR_W'(best) * ADDR_W'(LANE_DEPTH) + ADDR_W'(ptr_next);
		wr_addr  = ADDR_W'(cmd.lane) * ADDR_W'(LANE_DEPTH) + ADDR_W'(fill_q[cmd.lane]);
	end

	always_comb begin
		res_new.value     = found ? best_val : '0;
		res_new.lane      = found ? best : '0;
		res_new.empty_res = !found;
		res_new.last      = found ? last_c : 1'b1;
		res_new.overflow  = ovf_q;
	end

	assign res_full  = (res_cnt_q == 2'd2);
	assign res_empty = (res_cnt_q == 2'd0);
	assign res       = res_q[res_rd_q];
	assign res_push  = (state_q == ST_PICK) && !res_full;
	assign cmd_ready = (state_q == ST_IDLE);
	assign take_cmd  = cmd_valid && cmd_ready;
	assign push_ok   = take_cmd && (cmd.kind == CMD_PUSH) &&
		(fill_q[cmd.lane] != FILL_W'(LANE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drop_q  <= 1'b0;
			ovf_q   <= 1'b0;
			win_q   <= '0;
			for (int i = 0; i < LANES; i++) begin
				fill_q[i] <= '0;
				ptr_q[i]  <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take_cmd) begin
						case (cmd.kind)
							CMD_PUSH: begin
								if (push_ok) begin
									fill_q[cmd.lane] <= fill_q[cmd.lane] + FILL_W'(1);
								end else begin
									drop_q <= 1'b1;
								end
							end
							CMD_DROP: drop_q <= 1'b1;
							CMD_MERGE: begin
								ovf_q   <= drop_q;
								state_q <= ST_PICK;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_PICK: begin
					if (res_push) begin
						if (!found || last_c) begin
							// Drain finished: empty every lane and clear the sticky flag.
							drop_q  <= 1'b0;
							state_q <= ST_IDLE;
							for (int i = 0; i < LANES; i++) begin
								fill_q[i] <= '0;
								ptr_q[i]  <= '0;
							end
						end else begin
							ptr_q[best] <= ptr_next;
							win_q       <= best;
							state_q     <= ST_LOAD;
						end
					end
				end
				ST_LOAD: state_q <= ST_PICK;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Lane store and head copies; the head of an empty lane is taken on push.
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (push_ok) begin
			mem[wr_addr] <= cmd.value;
			if (fill_q[cmd.lane] == '0) begin
				head_q[cmd.lane] <= cmd.value;
			end
		end
		if (state_q == ST_LOAD) begin
			head_q[win_q] <= rd_data_q;
		end
	end

	// Result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (res_push) begin
				res_wr_q <= !res_wr_q;
			end
			if (res_pop && !res_empty) begin
				res_rd_q <= !res_rd_q;
			end
			case ({res_push, res_pop && !res_empty})
				2'b10:   res_cnt_q <= res_cnt_q + 2'd1;
				2'b01:   res_cnt_q <= res_cnt_q - 2'd1;
				default: res_cnt_q <= res_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q] <= res_new;
		end
	end

endmodule

FILE: verif/k_way_sorted_merge_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_test
// Self-checking bench for the k-way sorted merge: queued appends and merges
// are driven with random gaps on both sides, every popped result is checked
// against a behavioral merge model, and the lane count is swept across phases.
// ----------------------------------------------------------------------------
module k_way_sorted_merge_test;
	import kwm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_MERGE  = 1'b1;

	localparam int SEQ_NOISE    = 7;
	localparam int SEQ_OVERFILL = 8;
	localparam int SEQ_MERGE    = 9;

	localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VMIN = 32'sh8000_0000;

	typedef struct {
		logic                      mode;
		logic [LANE_W-1:0]         lane;
		logic signed [VALUE_W-1:0] value;
	} stim_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_W-1:0]          cfg_wdata = CFG_RESET;
	logic                      push = 1'b0;
	logic                      full;
	logic                      mode = 1'b0;
	logic [LANE_W-1:0]         lane = '0;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic signed [VALUE_W-1:0] out_value;
	logic [LANE_W-1:0]         out_lane;
	logic                      empty_res;
	logic                      last;
	logic                      overflow;

	// merge model state
	logic signed [VALUE_W-1:0] lane_vals [LANES][LANE_DEPTH];
	int                        lane_count [LANES];
	logic                      drop_pending = 1'b0;
	logic [CFG_W-1:0]          lanes_reg = CFG_RESET;
	res_t                      merged_q [$];

	stim_t stim_q [$];
	stim_t next_item;
	int    plan_act = LANES;
	int    planned = 0;
	bit    calm = 1'b0;

	bit in_took = 1'b0;
	bit res_took = 1'b0;
	int send_gap = 0;
	int pop_gap = 0;
	int pop_draw;

	int cycle_cnt = 0;
	int errors = 0;
	int items_in = 0;
	int merges_in = 0;
	int results_out = 0;

	logic [CFG_W-1:0] phase_lanes [8] = '{3'd4, 3'd3, 3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd4};

	k_way_sorted_merge u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.lane      (lane),
		.value     (value),
		.empty     (empty),
		.pop       (pop),
		.out_value (out_value),
		.out_lane  (out_lane),
		.empty_res (empty_res),
		.last      (last),
		.overflow  (overflow)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic signed [VALUE_W-1:0] rand_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return VMAX;
		if (r == 1)
			return VMIN;
		if (r < 5)
			return VALUE_W'($urandom_range(0, 6)) - 3;
		return $urandom;
	endfunction

	// Append or merge one transferred item and queue the results it produces.
	task automatic merge_or_append(input logic m, input logic [LANE_W-1:0] ln,
			input logic signed [VALUE_W-1:0] v);
		int   act;
		int   total;
		int   best;
		int   head [LANES];
		res_t r;
		act = (lanes_reg > LANES) ? LANES : int'(lanes_reg);
		if (m == MODE_APPEND) begin
			if (ln >= act || lane_count[ln] >= LANE_DEPTH) begin
				drop_pending = 1'b1;
			end else begin
				lane_vals[ln][lane_count[ln]] = v;
				lane_count[ln]++;
			end
			return;
		end
		total = 0;
		for (int i = 0; i < LANES; i++) begin
			head[i] = 0;
			if (i < act)
				total += lane_count[i];
		end
		if (total == 0) begin
			r = '0;
			r.empty_res = 1'b1;
			r.last = 1'b1;
			r.overflow = drop_pending;
			merged_q.push_back(r);
		end
		for (int n = 0; n < total; n++) begin
			best = -1;
			// strict less-than keeps the lowest lane on equal heads
			for (int i = 0; i < act; i++) begin
				if (head[i] < lane_count[i] &&
						(best < 0 || lane_vals[i][head[i]] < lane_vals[best][head[best]]))
					best = i;
			end
			r.value = lane_vals[best][head[best]];
			r.lane = LANE_W'(best);
			r.empty_res = 1'b0;
			r.last = (n == total - 1);
			r.overflow = drop_pending;
			merged_q.push_back(r);
			head[best]++;
		end
		for (int i = 0; i < LANES; i++)
			lane_count[i] = 0;
		drop_pending = 1'b0;
	endtask

	task automatic field_cmp(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic add_item(input logic m, input int ln, input logic signed [VALUE_W-1:0] v);
		stim_t s;
		s.mode = m;
		s.lane = LANE_W'(ln);
		s.value = v;
		stim_q.push_back(s);
		if (m == MODE_MERGE || ln < plan_act)
			planned++;
	endtask

	task automatic add_sequence(input int kind);
		int n;
		int ln;
		if (kind == SEQ_NOISE) begin
			n = $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				add_item(($urandom_range(0, 3) == 0) ? MODE_MERGE : MODE_APPEND,
					$urandom_range(0, LANES - 1), $urandom);
		end else if (kind == SEQ_MERGE) begin
			add_item(MODE_MERGE, $urandom_range(0, LANES - 1), $urandom);
			if ($urandom_range(0, 1))
				add_item(MODE_MERGE, $urandom_range(0, LANES - 1), $urandom);
		end else begin
			// overfill fills one lane to at least its depth; others are well-formed lists
			n = (kind == SEQ_OVERFILL) ? $urandom_range(LANE_DEPTH, LANE_DEPTH + 3)
				: $urandom_range(0, 12);
			ln = (plan_act > 0) ? $urandom_range(0, plan_act - 1) : $urandom_range(0, LANES - 1);
			for (int i = 0; i < n; i++) begin
				if (kind != SEQ_OVERFILL)
					ln = (plan_act > 0) ? $urandom_range(0, plan_act - 1)
						: $urandom_range(0, LANES - 1);
				add_item(MODE_APPEND, ln, rand_value());
			end
			add_item(MODE_MERGE, $urandom_range(0, LANES - 1), $urandom);
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (stim_q.size() != 0 || push || merged_q.size() != 0);
	endtask

	task automatic set_lanes(input logic [CFG_W-1:0] n);
		wait_idle();
		// let trailing appends retire before touching the register
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n;
		@(negedge clk);
		cfg_we <= 1'b0;
		lanes_reg = n;
		plan_act = (n > LANES) ? LANES : int'(n);
		@(posedge clk);
	endtask

	// input driver
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || in_took) begin
			if (send_gap != 0) begin
				push <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (stim_q.size() != 0) begin
				next_item = stim_q.pop_front();
				push <= 1'b1;
				mode <= next_item.mode;
				lane <= next_item.lane;
				value <= next_item.value;
				send_gap <= pick_gap();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result side pop with random stalls after transfers
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_gap != 0) begin
			pop <= 1'b0;
			pop_gap <= pop_gap - 1;
		end else begin
			pop_draw = pick_gap();
			if (res_took && pop_draw != 0) begin
				pop <= 1'b0;
				pop_gap <= pop_draw - 1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// monitor: predict on input transfer, check on result transfer
	always @(posedge clk) begin
		res_t want;
		cycle_cnt <= cycle_cnt + 1;
		in_took <= arst_n && push && !full;
		res_took <= arst_n && pop && !empty;
		if (arst_n && push && !full) begin
			merge_or_append(mode, lane, value);
			items_in++;
			if (mode == MODE_MERGE)
				merges_in++;
		end
		if (arst_n && pop && !empty) begin
			results_out++;
			if (merged_q.size() == 0) begin
				$display("%0t: unexpected result value %0d lane %0d empty_res %0b last %0b",
					$time, out_value, out_lane, empty_res, last);
				errors++;
			end else begin
				want = merged_q.pop_front();
				field_cmp("out_value", want.value, out_value);
				field_cmp("out_lane", want.lane, out_lane);
				field_cmp("empty_res", want.empty_res, empty_res);
				field_cmp("last", want.last, last);
				field_cmp("overflow", want.overflow, overflow);
			end
		end
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("%0t: timeout, %0d results still expected", $time, merged_q.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin
		for (int i = 0; i < LANES; i++)
			lane_count[i] = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty merge, extremes, ties on both low and high values
		add_item(MODE_MERGE, 0, 0);
		add_item(MODE_APPEND, 0, -1);
		add_item(MODE_APPEND, 1, VMIN);
		add_item(MODE_APPEND, 2, 0);
		add_item(MODE_APPEND, 3, -1);
		add_item(MODE_APPEND, 0, VMAX);
		add_item(MODE_APPEND, 3, -1);
		add_item(MODE_APPEND, 1, VMIN);
		add_item(MODE_APPEND, 2, VMAX);
		add_item(MODE_MERGE, 3, VMAX);
		// lower the lane count over filled upper lanes; merge discards them
		add_item(MODE_APPEND, 3, 5);
		add_item(MODE_APPEND, 2, 6);
		set_lanes(3'd2);
		add_item(MODE_MERGE, 1, 0);
		add_item(MODE_APPEND, 3, 9);
		add_item(MODE_APPEND, 1, 4);
		add_item(MODE_MERGE, 2, 0);
		// no active lanes: drop, then empty merge carrying overflow
		set_lanes(3'd0);
		add_item(MODE_APPEND, 0, 1);
		add_item(MODE_MERGE, 0, 0);
		// count above the lane total acts as all lanes
		set_lanes(3'd7);
		add_item(MODE_APPEND, 3, -5);
		add_item(MODE_APPEND, 0, 5);
		add_item(MODE_MERGE, 1, -1);

		foreach (phase_lanes[p]) begin
			set_lanes(phase_lanes[p]);
			calm = ($urandom_range(0, 3) == 0);
			planned = 0;
			add_sequence((p == 0) ? SEQ_OVERFILL : $urandom_range(0, 9));
			while (planned < ((plan_act == 0) ? 2 : 8))
				add_sequence($urandom_range(0, 9));
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Transferred %0d items (%0d merges), checked %0d results", items_in,
			merges_in, results_out);
		$display("Lane counts swept from zero to seven, lanes overfilled and lowered");
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
